// ----- hdl/wpm_pkg.sv -----
`default_nettype none

package wpm_pkg;

    localparam logic [7:0] SYM_STAR = 8'h2A;
    localparam logic [7:0] SYM_ANY  = 8'h3F;

    typedef enum logic [1:0] {
        ACT_APPEND  = 2'd0,
        ACT_TEXT    = 2'd1,
        ACT_RESTART = 2'd2,
        ACT_CLEAR   = 2'd3
    } action_t;

    typedef struct packed {
        action_t    action;
        logic [7:0] symbol;
    } in_t;

    typedef struct packed {
        logic matched;
        logic pattern_full;
    } out_t;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        logic       load;
        action_t    action;
        logic [7:0] symbol;
    } cmd_t;

    // Signals handed from one cell to its right neighbor.
    typedef struct packed {
        logic active;
        logic vec;
        logic adv;
        logic rst;
    } link_t;

endpackage

`default_nettype wire

// ----- hdl/wpm_cell.sv -----
`default_nettype none

module wpm_cell (
    input  wire              clk,
    input  wire              rst_n,
    input  wpm_pkg::cmd_t    cmd,
    input  wpm_pkg::link_t   left,
    output wpm_pkg::link_t   right,
    output logic             vec_next,
    output logic             active_next
);
    import wpm_pkg::*;

    logic       active_reg;
    logic       vec_reg;
    logic [7:0] sym_reg;
    logic       write_here;
    logic [7:0] sym_next;
    logic       sym_is_star;
    logic       adv;
    logic       rst_chain;

    always_comb
    begin
        write_here  = (cmd.action == ACT_APPEND) && left.active && !active_reg;
        sym_next    = write_here ? cmd.symbol : sym_reg;
        active_next = (cmd.action == ACT_CLEAR) ? 1'b0 : (active_reg || write_here);
        sym_is_star = (sym_reg == SYM_STAR);

        if (!active_reg)
        begin
            adv = 1'b0;
        end
        else if (sym_is_star)
        begin
            adv = left.adv || vec_reg;
        end
        else
        begin
            adv = ((sym_reg == SYM_ANY) || (sym_reg == cmd.symbol)) && left.vec;
        end

        rst_chain = active_next && (sym_next == SYM_STAR) && left.rst;
        vec_next  = (cmd.action == ACT_TEXT) ? adv : rst_chain;

        right.active = active_reg;
        right.vec    = vec_reg;
        right.adv    = adv;
        right.rst    = rst_chain;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            vec_reg    <= 1'b0;
        end
        else if (cmd.load)
        begin
            active_reg <= active_next;
            vec_reg    <= vec_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && write_here)
        begin
            sym_reg <= cmd.symbol;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/wildcard_pattern_matcher.sv -----
`default_nettype none

// Streams text bytes against a stored glob pattern of up to MAX_PATTERN bytes, where '*'
// matches any run of bytes and '?' matches any one byte. Each input transaction appends a
// pattern byte, advances the text by one byte, restarts the text, or clears the pattern,
// and produces exactly one output transaction telling whether the text so far matches
// the whole pattern and whether an append was dropped because the pattern was full.
// The pattern is held in a row of cells, one per pattern byte, each keeping its byte and
// one prefix-match bit; all cells update together, so one transaction is taken every
// cycle while the output register is free or being drained; the result is registered.
module wildcard_pattern_matcher #(
    parameter int MAX_PATTERN = 32
) (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            in_valid,
    output logic           in_ready,
    input  wpm_pkg::in_t   in_data,
    output logic           out_valid,
    input  wire            out_ready,
    output wpm_pkg::out_t  out_data
);
    import wpm_pkg::*;

    cmd_t       cmd;
    link_t      links [MAX_PATTERN+1];
    logic       vecn  [MAX_PATTERN+1];
    logic       actn  [MAX_PATTERN+2];
    logic       hit   [MAX_PATTERN+1];
    logic       vec0_reg;
    logic       out_valid_reg;
    out_t       out_data_reg;
    logic       accept;
    logic       matched_next;
    logic       full_next;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign cmd.load   = accept;
    assign cmd.action = in_data.action;
    assign cmd.symbol = in_data.symbol;

    assign links[0].active = 1'b1;
    assign links[0].vec    = vec0_reg;
    assign links[0].adv    = 1'b0;
    assign links[0].rst    = 1'b1;

    assign vecn[0]             = (in_data.action != ACT_TEXT);
    assign actn[0]             = 1'b1;
    assign actn[MAX_PATTERN+1] = 1'b0;

    genvar g;
    generate
        for (g = 1; g <= MAX_PATTERN; g++)
        begin : g_cell
            wpm_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .left        (links[g-1]),
                .right       (links[g]),
                .vec_next    (vecn[g]),
                .active_next (actn[g])
            );
        end
        for (g = 0; g <= MAX_PATTERN; g++)
        begin : g_hit
            assign hit[g] = vecn[g] && actn[g] && !actn[g+1];
        end
    endgenerate

    always_comb
    begin
        matched_next = 1'b0;
        for (int j = 0; j <= MAX_PATTERN; j++)
        begin
            matched_next = matched_next || hit[j];
        end
        full_next = (in_data.action == ACT_APPEND) && links[MAX_PATTERN].active;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vec0_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                vec0_reg <= vecn[0];
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg.matched      <= matched_next;
            out_data_reg.pattern_full <= full_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
module tb;
    import wpm_pkg::*;

    localparam int PAT_CAP = 32;
    localparam int RANDOM_ITEMS = 1350;
    localparam int IDLE_LIMIT = 2000;

    logic clk;
    logic rst_n;
    logic in_valid = 1'b0;
    logic in_ready;
    in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_data;

    in_t pending_q[$];
    out_t match_q[$];
    logic [7:0] text_bytes[$];
    logic [7:0] shadow_pattern[$];

    logic [7:0] pat_mem [PAT_CAP];
    int pat_len = 0;
    logic [PAT_CAP:0] prefix_hits = {{PAT_CAP{1'b0}}, 1'b1};

    int fail_count = 0;
    int idle_cycles = 0;
    int burst_left = 8;
    int gap_left = 0;
    int stall_mode = 0;
    int stall_left = 0;
    int stall_phase = 0;

    wildcard_pattern_matcher #(
        .MAX_PATTERN(PAT_CAP)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic out_t glob_step(in_t item);
        logic [PAT_CAP:0] nxt;
        out_t res;
        int j;
        res = '0;
        nxt = '0;
        case (item.action)
            ACT_APPEND:
            begin
                if (pat_len < PAT_CAP)
                begin
                    pat_mem[pat_len] = item.symbol;
                    pat_len++;
                end
                else
                begin
                    res.pattern_full = 1'b1;
                end
            end
            ACT_TEXT:
            begin
                for (j = 1; j <= pat_len; j++)
                begin
                    if (pat_mem[j - 1] == SYM_STAR)
                        nxt[j] = nxt[j - 1] | prefix_hits[j];
                    else if (pat_mem[j - 1] == SYM_ANY || pat_mem[j - 1] == item.symbol)
                        nxt[j] = prefix_hits[j - 1];
                end
                prefix_hits = nxt;
            end
            ACT_CLEAR:
            begin
                pat_len = 0;
            end
            default:
            begin
            end
        endcase
        if (item.action != ACT_TEXT)
        begin
            prefix_hits = '0;
            prefix_hits[0] = 1'b1;
            for (j = 1; j <= pat_len; j++)
                prefix_hits[j] = prefix_hits[j - 1] && pat_mem[j - 1] == SYM_STAR;
        end
        res.matched = prefix_hits[pat_len];
        return res;
    endfunction

    task automatic put(action_t act, logic [7:0] sym);
        in_t item;
        item.action = act;
        item.symbol = sym;
        pending_q.push_back(item);
        if (act == ACT_APPEND && shadow_pattern.size() < PAT_CAP)
            shadow_pattern.push_back(sym);
        else if (act == ACT_CLEAR)
            shadow_pattern.delete();
    endtask

    function automatic logic [7:0] pattern_symbol();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return SYM_STAR;
        else if (r < 5)
            return SYM_ANY;
        else if (r < 9)
            return 8'h61 + 8'($urandom_range(0, 2));
        return 8'($urandom());
    endfunction

    function automatic logic [7:0] text_symbol();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return SYM_STAR;
        else if (r == 1)
            return 8'($urandom());
        return 8'h61 + 8'($urandom_range(0, 2));
    endfunction

    task automatic build_stimulus();
        int seq_no;
        int plen;
        int texts;
        int k;
        int r;
        int pos;
        put(ACT_RESTART, 8'hFF);
        put(ACT_TEXT, 8'h00);
        put(ACT_TEXT, 8'hFF);
        put(ACT_CLEAR, 8'h00);
        put(ACT_APPEND, SYM_STAR);
        put(ACT_TEXT, SYM_STAR);
        put(ACT_TEXT, 8'h00);
        put(ACT_APPEND, SYM_ANY);
        put(ACT_TEXT, 8'hFF);
        put(ACT_TEXT, SYM_STAR);
        put(ACT_APPEND, 8'h00);
        put(ACT_TEXT, 8'h41);
        put(ACT_TEXT, 8'h00);
        put(ACT_TEXT, 8'hFF);
        put(ACT_RESTART, SYM_STAR);
        put(ACT_TEXT, SYM_ANY);
        put(ACT_TEXT, 8'h00);
        put(ACT_APPEND, SYM_STAR);
        put(ACT_TEXT, 8'h80);
        put(ACT_TEXT, 8'h00);
        put(ACT_CLEAR, 8'hFF);
        put(ACT_APPEND, 8'hFF);
        put(ACT_TEXT, 8'hFF);
        put(ACT_TEXT, 8'hFF);

        seq_no = 0;
        while (pending_q.size() < RANDOM_ITEMS + 24)
        begin
            if (seq_no > 0 && $urandom_range(0, 19) == 0)
            begin
                repeat ($urandom_range(1, 6))
                    put(action_t'($urandom_range(0, 3)), 8'($urandom()));
            end
            else
            begin
                if (seq_no == 0 || $urandom_range(0, 3) != 0)
                    put(ACT_CLEAR, 8'($urandom()));
                if (seq_no == 0)
                    plen = PAT_CAP + 2;
                else if ($urandom_range(0, 9) == 0)
                    plen = $urandom_range(PAT_CAP - 4, PAT_CAP + 4);
                else
                    plen = $urandom_range(0, 7);
                repeat (plen)
                    put(ACT_APPEND, pattern_symbol());
                texts = $urandom_range(1, 3);
                for (k = 0; k < texts; k++)
                begin
                    if (k > 0 || plen == 0)
                        put(ACT_RESTART, 8'($urandom()));
                    text_bytes.delete();
                    foreach (shadow_pattern[i])
                    begin
                        if (shadow_pattern[i] == SYM_STAR)
                            repeat ($urandom_range(0, 3))
                                text_bytes.push_back(text_symbol());
                        else if (shadow_pattern[i] == SYM_ANY)
                            text_bytes.push_back(8'($urandom()));
                        else
                            text_bytes.push_back(shadow_pattern[i]);
                    end
                    r = $urandom_range(0, 7);
                    if (r == 0 && text_bytes.size() > 0)
                    begin
                        pos = $urandom_range(0, text_bytes.size() - 1);
                        text_bytes[pos] = text_symbol();
                    end
                    else if (r == 1 && text_bytes.size() > 0)
                    begin
                        void'(text_bytes.pop_back());
                    end
                    else if (r == 2)
                    begin
                        text_bytes.push_back(text_symbol());
                    end
                    foreach (text_bytes[i])
                        put(ACT_TEXT, text_bytes[i]);
                end
            end
            seq_no++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : driver
        logic take_new;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else
        begin
            take_new = !in_valid;
            if (in_valid && in_ready)
            begin
                match_q.push_back(glob_step(in_data));
                take_new = 1'b1;
            end
            if (take_new)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    in_valid <= 1'b1;
                    in_data <= pending_q.pop_front();
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        gap_left = $urandom_range(1, 6);
                        if ($urandom_range(0, 7) == 0)
                            burst_left = $urandom_range(40, 120);
                        else
                            burst_left = $urandom_range(1, 12);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor
        out_t want;
        logic ready_next;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (match_q.size() == 0)
                begin
                    $display("%0t: unexpected transaction, expected none actual %b",
                             $time, out_data);
                    fail_count++;
                end
                else
                begin
                    want = match_q.pop_front();
                    if (out_data.matched !== want.matched)
                    begin
                        $display("%0t: matched expected %b actual %b",
                                 $time, want.matched, out_data.matched);
                        fail_count++;
                    end
                    if (out_data.pattern_full !== want.pattern_full)
                    begin
                        $display("%0t: pattern_full expected %b actual %b",
                                 $time, want.pattern_full, out_data.pattern_full);
                        fail_count++;
                    end
                end
            end
            if (stall_left <= 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(20, 200);
            end
            stall_left--;
            stall_phase++;
            case (stall_mode)
                0: ready_next = 1'b1;
                1: ready_next = ($urandom_range(0, 1) == 1);
                2: ready_next = ($urandom_range(0, 3) == 0);
                default: ready_next = (stall_phase % 5) < 2;
            endcase
            out_ready <= ready_next;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        build_stimulus();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_q.size() != 0 || in_valid)
            @(posedge clk);
        while (match_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
